FILE: rtl/pfe_pkg.sv
// Package for the protobuf field encoder: item modes, sequencer states,
// the control bundle between sequencer and datapath, and tag helpers.
// No dependencies.
package pfe_pkg;

   // Field request kinds carried in req_mode
   typedef enum logic [1:0] {
      MODE_VARINT  = 2'd0,
      MODE_FIXED32 = 2'd1,
      MODE_LEN     = 2'd2,
      MODE_RAW     = 2'd3
   } mode_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAG,
      ST_VARINT,
      ST_FIXED,
      ST_RAW
   } state_type;

   // Wire types placed in the low bits of a tag
   localparam logic [2:0] WT_VARINT  = 3'd0;
   localparam logic [2:0] WT_LEN     = 3'd2;
   localparam logic [2:0] WT_FIXED32 = 3'd5;

   localparam int unsigned FIELD_W   = 29;
   localparam int unsigned VALUE_W   = 64;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned GROUP_W   = 7;
   localparam int unsigned TAG_W     = FIELD_W + 3;
   localparam logic [1:0]  FIXED_LAST = 2'd3;

   // Control from the sequencer to the datapath
   typedef struct packed {
      logic ld_req;     // load the work register from the accepted item
      logic ld_value;   // load the saved value after the tag is out
      logic step;       // emit one byte and shift the work register
      logic byte_mode;  // 8-bit chunks instead of 7-bit varint groups
      logic last;       // emitted byte closes the item
   } ctl_type;

   // Wire type for a mode
   function automatic logic [2:0] mode_wire_bits(input mode_type mode);
      logic [2:0] wt;
      case (mode)
         MODE_VARINT:  wt = WT_VARINT;
         MODE_FIXED32: wt = WT_FIXED32;
         MODE_LEN:     wt = WT_LEN;
         default:      wt = WT_VARINT;
      endcase
      return wt;
   endfunction

endpackage

FILE: rtl/protobuf_field_encoder_top.sv
// Protobuf field encoder, top level: one field request in, its wire bytes out.
// An accepted item is loaded into the work register; each byte is registered at rsp.
// An item is N bytes (1 to 15); the single shift unit cuts one byte per cycle while
// rsp is not stalled, and no new item is taken until the last byte of the item is cut.
// Reset: synchronous, active high; clears the sequencer and the output valid.
module protobuf_field_encoder_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_mode,
   input  logic [pfe_pkg::FIELD_W-1:0]        req_field_number,
   input  logic [pfe_pkg::VALUE_W-1:0]        req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pfe_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic                               rsp_last
);

   pfe_pkg::ctl_type             ctl;
   pfe_pkg::mode_type            mode;
   logic                         req_fire;
   logic                         emit;
   logic                         unit_done;
   logic [pfe_pkg::BYTE_W-1:0]   unit_byte;
   logic [pfe_pkg::VALUE_W-1:0]  unit_rest;
   logic [pfe_pkg::TAG_W-1:0]    tag;

   logic [pfe_pkg::VALUE_W-1:0]  work_ff, work_in;
   logic [pfe_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [pfe_pkg::BYTE_W-1:0]   rsp_byte_ff, rsp_byte_in;
   logic                         rsp_last_ff, rsp_last_in;

   assign mode     = pfe_pkg::mode_type'(req_mode);
   assign req_fire = req_valid && req_ready;
   assign emit     = !rsp_valid_ff || rsp_ready;
   assign tag      = {req_field_number, pfe_pkg::mode_wire_bits(mode)};

   pfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_mode  (mode),
      .emit      (emit),
      .unit_done (unit_done),
      .req_ready (req_ready),
      .ctl       (ctl)
   );

   pfe_unit u_unit (
      .work      (work_ff),
      .byte_mode (ctl.byte_mode),
      .out_byte  (unit_byte),
      .rest      (unit_rest),
      .done      (unit_done)
   );

   // Load tag or raw value on accept, reload value after tag, else shift
   always_comb begin
      work_in = work_ff;
      if (ctl.ld_req) begin
         if (mode == pfe_pkg::MODE_RAW) begin
            work_in = req_value;
         end else begin
            work_in = {{(pfe_pkg::VALUE_W-pfe_pkg::TAG_W){1'b0}}, tag};
         end
      end else if (ctl.ld_value) begin
         work_in = value_ff;
      end else if (ctl.step) begin
         work_in = unit_rest;
      end
   end

   // Hold the value while the tag goes out
   assign value_in = req_fire ? req_value : value_ff;

   // Output register: fill on a step, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (ctl.step) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = unit_byte;
         rsp_last_in  = ctl.last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      work_ff     <= work_in;
      value_ff    <= value_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

FILE: rtl/pfe_unit.sv
// Shared shift-and-compare unit of the protobuf field encoder.
// Cuts one wire byte off the work word and reports whether a varint ends.
// Depends on pfe_pkg.
module pfe_unit (
   input  logic [pfe_pkg::VALUE_W-1:0] work,
   input  logic                        byte_mode,
   output logic [pfe_pkg::BYTE_W-1:0]  out_byte,
   output logic [pfe_pkg::VALUE_W-1:0] rest,
   output logic                        done
);

   // Varint ends when nothing remains above the low group
   assign done = (work[pfe_pkg::VALUE_W-1:pfe_pkg::GROUP_W] == '0);

   // Pick the byte: raw octet, or group with continuation bit
   always_comb begin
      if (byte_mode) begin
         out_byte = work[pfe_pkg::BYTE_W-1:0];
         rest     = work >> pfe_pkg::BYTE_W;
      end else begin
         out_byte = {~done, work[pfe_pkg::GROUP_W-1:0]};
         rest     = work >> pfe_pkg::GROUP_W;
      end
   end

endmodule

FILE: rtl/pfe_ctrl.sv
// Sequencer of the protobuf field encoder: walks tag, value and raw phases
// and drives the shared unit one byte per step.
// Depends on pfe_pkg.
module pfe_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  pfe_pkg::mode_type req_mode,
   input  logic              emit,
   input  logic              unit_done,
   output logic              req_ready,
   output pfe_pkg::ctl_type  ctl
);

   pfe_pkg::state_type state_ff, state_in;
   pfe_pkg::mode_type  mode_ff, mode_in;
   logic [1:0]         cnt_ff, cnt_in;

   // Hold state, mode and fixed32 byte count
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pfe_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      mode_ff <= mode_in;
   end

   // Latch the mode of an accepted item
   assign mode_in = req_fire ? req_mode : mode_ff;

   // Advance the fixed32 byte count
   always_comb begin
      if (state_ff == pfe_pkg::ST_FIXED) begin
         cnt_in = emit ? cnt_ff + 2'd1 : cnt_ff;
      end else begin
         cnt_in = '0;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfe_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_mode == pfe_pkg::MODE_RAW) ? pfe_pkg::ST_RAW : pfe_pkg::ST_TAG;
            end
         end
         pfe_pkg::ST_TAG: begin
            if (emit && unit_done) begin
               state_in = (mode_ff == pfe_pkg::MODE_FIXED32) ? pfe_pkg::ST_FIXED
                                                             : pfe_pkg::ST_VARINT;
            end
         end
         pfe_pkg::ST_VARINT: begin
            if (emit && unit_done) state_in = pfe_pkg::ST_IDLE;
         end
         pfe_pkg::ST_FIXED: begin
            if (emit && cnt_ff == pfe_pkg::FIXED_LAST) state_in = pfe_pkg::ST_IDLE;
         end
         pfe_pkg::ST_RAW: begin
            if (emit) state_in = pfe_pkg::ST_IDLE;
         end
         default: state_in = pfe_pkg::ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      ctl       = '0;
      req_ready = (state_ff == pfe_pkg::ST_IDLE);
      case (state_ff)
         pfe_pkg::ST_IDLE: begin
            ctl.ld_req = req_fire;
         end
         pfe_pkg::ST_TAG: begin
            ctl.step     = emit;
            ctl.ld_value = emit && unit_done;
         end
         pfe_pkg::ST_VARINT: begin
            ctl.step = emit;
            ctl.last = unit_done;
         end
         pfe_pkg::ST_FIXED: begin
            ctl.step      = emit;
            ctl.byte_mode = 1'b1;
            ctl.last      = (cnt_ff == pfe_pkg::FIXED_LAST);
         end
         pfe_pkg::ST_RAW: begin
            ctl.step      = emit;
            ctl.byte_mode = 1'b1;
            ctl.last      = 1'b1;
         end
         default: ctl = '0;
      endcase
   end

   // Value reload only ever closes a tag step
   a_ld_value: assert property (@(posedge clock) disable iff (reset)
      ctl.ld_value |-> (ctl.step && state_ff == pfe_pkg::ST_TAG))
      else $error("value reload outside tag step");

   // Byte count runs only in the fixed32 phase
   a_cnt_phase: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 2'd0) |-> (state_ff == pfe_pkg::ST_FIXED))
      else $error("fixed32 count outside fixed phase");

   // Raw item takes exactly one byte
   a_raw_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfe_pkg::ST_RAW && emit) |=> (state_ff == pfe_pkg::ST_IDLE))
      else $error("raw item did not finish after one byte");

endmodule

FILE: verif/protobuf_field_encoder_top_tb.sv
// Self-checking testbench for protobuf_field_encoder_top: drives field requests,
// predicts each wire byte and its last flag, and checks them under random stalls.
// Depends on rtl/pfe_pkg.sv and rtl/protobuf_field_encoder_top.sv.
module protobuf_field_encoder_top_tb;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } wire_byte_type;

   logic                          clock            = 1'b0;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic [1:0]                    req_mode         = '0;
   logic [pfe_pkg::FIELD_W-1:0]   req_field_number = '0;
   logic [pfe_pkg::VALUE_W-1:0]   req_value        = '0;
   logic                          rsp_ready        = 1'b0;
   logic                          req_ready;
   logic                          rsp_valid;
   logic [pfe_pkg::BYTE_W-1:0]    rsp_out_byte;
   logic                          rsp_last;

   // Wire bytes still owed by the encoder, oldest first
   wire_byte_type expected_bytes[$];
   wire_byte_type want_byte;

   // Scratch space for building the bytes of one field
   logic [7:0] enc_buf[0:14];
   int         enc_len;

   int fail_count    = 0;
   int bytes_checked = 0;
   int items_sent    = 0;
   int mode_count[4] = '{0, 0, 0, 0};
   bit quiet         = 1'b0;

   protobuf_field_encoder_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_field_number (req_field_number),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      #8000000;
      $display("timeout: %0d wire bytes still outstanding", expected_bytes.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Byte predictor
   // ---------------------------------------------------------------------
   function automatic void emit_byte(input logic [7:0] b);
      enc_buf[enc_len] = b;
      enc_len++;
   endfunction

   // Append a varint: 7-bit groups, low group first, continuation bit on all but the last
   function automatic void emit_varint(input logic [63:0] v);
      while (v >= 64'h80) begin
         emit_byte({1'b1, v[6:0]});
         v = v >> 7;
      end
      emit_byte({1'b0, v[6:0]});
   endfunction

   // Queue the wire bytes of one field request
   function automatic void predict_wire_bytes(input pfe_pkg::mode_type m,
                                              input logic [28:0] fnum,
                                              input logic [63:0] v);
      wire_byte_type wb;
      enc_len = 0;
      case (m)
         pfe_pkg::MODE_VARINT: begin
            emit_varint({32'd0, fnum, pfe_pkg::WT_VARINT});
            emit_varint(v);
         end
         pfe_pkg::MODE_FIXED32: begin
            emit_varint({32'd0, fnum, pfe_pkg::WT_FIXED32});
            for (int k = 0; k < 4; k++) emit_byte(v[8*k +: 8]);
         end
         pfe_pkg::MODE_LEN: begin
            emit_varint({32'd0, fnum, pfe_pkg::WT_LEN});
            emit_varint(v);
         end
         default: begin
            emit_byte(v[7:0]);
         end
      endcase
      for (int i = 0; i < enc_len; i++) begin
         wb.data = enc_buf[i];
         wb.last = (i == enc_len - 1);
         expected_bytes.push_back(wb);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Random helpers
   // ---------------------------------------------------------------------
   // Idle length: mostly none or short, a few long; none in quiet phases
   function automatic int pick_delay();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Random value with a random significant length, so every varint size shows up
   function automatic logic [63:0] rand_value();
      int          w;
      logic [63:0] v;
      w = $urandom_range(0, 64);
      v = {$urandom, $urandom};
      if (w < 64) v = v & ((64'd1 << w) - 64'd1);
      return v;
   endfunction

   function automatic logic [28:0] rand_field_number();
      int          w;
      logic [28:0] f;
      w = $urandom_range(0, 29);
      f = 29'($urandom);
      if (w < 29) f = f & ((29'd1 << w) - 29'd1);
      return f;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Send one field request; returns at the edge that accepts it
   task automatic send_field(input pfe_pkg::mode_type m, input logic [28:0] fnum,
                             input logic [63:0] v);
      int gap;
      gap = pick_delay();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= m;
      req_field_number <= fnum;
      req_value        <= v;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      predict_wire_bytes(m, fnum, v);
      mode_count[m]++;
      items_sent++;
      @(posedge clock);
   endtask

   // Drop valid and hold until every predicted byte has come out
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------
   // Toggle ready in runs; stalls vanish in quiet phases
   initial begin : rsp_backpressure
      int run;
      int stall;
      forever begin
         run = $urandom_range(1, 12);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         stall = pick_delay();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Compare each accepted byte against the oldest prediction
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected wire byte %02h last %0b",
                        $realtime, rsp_out_byte, rsp_last);
         end else begin
            want_byte = expected_bytes.pop_front();
            bytes_checked++;
            if (rsp_out_byte !== want_byte.data || rsp_last !== want_byte.last) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
                           $realtime, want_byte.data, want_byte.last,
                           rsp_out_byte, rsp_last);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Field extremes, varint size boundaries and ignored bits in each mode
   task automatic test_directed();
      send_field(pfe_pkg::MODE_VARINT, 29'd0, 64'd0);
      send_field(pfe_pkg::MODE_VARINT, 29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_field(pfe_pkg::MODE_VARINT, 29'd1, 64'h7F);
      send_field(pfe_pkg::MODE_VARINT, 29'd15, 64'h80);
      send_field(pfe_pkg::MODE_VARINT, 29'd16, 64'h3FFF);
      send_field(pfe_pkg::MODE_VARINT, 29'd2047, 64'h4000);
      send_field(pfe_pkg::MODE_VARINT, 29'd1, 64'h8000_0000_0000_0000);
      send_field(pfe_pkg::MODE_VARINT, 29'h0FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
      // fixed32: upper half of the value must not leak out
      send_field(pfe_pkg::MODE_FIXED32, 29'd0, 64'd0);
      send_field(pfe_pkg::MODE_FIXED32, 29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_field(pfe_pkg::MODE_FIXED32, 29'd3, 64'hDEAD_BEEF_1234_5678);
      send_field(pfe_pkg::MODE_FIXED32, 29'd5, 64'h0000_0000_8000_0001);
      // length headers, one of them followed by its payload as raw bytes
      send_field(pfe_pkg::MODE_LEN, 29'd0, 64'd0);
      send_field(pfe_pkg::MODE_LEN, 29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_field(pfe_pkg::MODE_LEN, 29'd2, 64'd3);
      send_field(pfe_pkg::MODE_RAW, 29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FF00);
      send_field(pfe_pkg::MODE_RAW, 29'd0, 64'h0000_0000_0000_00FF);
      send_field(pfe_pkg::MODE_RAW, 29'h0AAA_AAAA, 64'h5555_5555_5555_55A5);
      send_field(pfe_pkg::MODE_LEN, 29'd7, 64'd300);
      wait_drained();
   endtask

   // Unrelated field requests with random content
   task automatic test_random_fields(input int count);
      repeat (count)
         send_field(pfe_pkg::mode_type'($urandom_range(0, 3)), rand_field_number(),
                    rand_value());
   endtask

   // Message-shaped streams: scalar fields, then a length header and its payload
   task automatic test_messages(input int count);
      int scalars;
      int len;
      int sent;
      repeat (count) begin
         scalars = $urandom_range(1, 3);
         repeat (scalars)
            send_field($urandom_range(0, 1) ? pfe_pkg::MODE_FIXED32 : pfe_pkg::MODE_VARINT,
                       rand_field_number(), rand_value());
         len = $urandom_range(0, 6);
         send_field(pfe_pkg::MODE_LEN, rand_field_number(), 64'(len));
         // now and then cut the payload short or slip a stray field in
         sent = ($urandom_range(0, 7) == 0) ? $urandom_range(0, len) : len;
         for (int i = 0; i < sent; i++) begin
            if ($urandom_range(0, 15) == 0)
               send_field(pfe_pkg::MODE_VARINT, rand_field_number(), rand_value());
            send_field(pfe_pkg::MODE_RAW, 29'($urandom), {$urandom, $urandom});
         end
      end
   endtask

   // Back-to-back requests with the receiver always ready
   task automatic test_back_to_back(input int count);
      wait_drained();
      quiet = 1'b1;
      test_random_fields(count);
      wait_drained();
      quiet = 1'b0;
   endtask

   // Let the encoder go fully idle between short bursts
   task automatic test_pause_for_drain();
      repeat (4) begin
         test_random_fields(3);
         wait_drained();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_fields(140);
      test_messages(20);
      test_back_to_back(30);
      test_pause_for_drain();

      wait_drained();
      repeat (20) @(posedge clock);

      $display("covered %0d field requests: %0d varint, %0d fixed32, %0d length, %0d raw",
               items_sent, mode_count[pfe_pkg::MODE_VARINT],
               mode_count[pfe_pkg::MODE_FIXED32],
               mode_count[pfe_pkg::MODE_LEN], mode_count[pfe_pkg::MODE_RAW]);
      $display("checked %0d wire bytes under random gaps and stalls, %0d failures",
               bytes_checked, fail_count);
      if (fail_count == 0 && expected_bytes.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
